>>> design/ertt_pkg.sv
// Shared types and constants for the echo range threat tracker.
// No dependencies; every module of the block imports this package.
package ertt_pkg;

  // Timer and arithmetic widths.
  localparam int ERTT_TIMER_BITS = 16;
  localparam int CAP_W           = 16;
  localparam int WRAP_W          = 16;
  localparam int PULSE_W         = 32;
  localparam int DIST_W          = 27;
  localparam int CM_W            = 14;
  localparam int LIMIT_W         = 14;
  localparam int USER_W          = 2;
  localparam int IN_DATA_W       = 16;
  localparam int OUT_DATA_W      = 48;

  // Q16 form of 0.01715 cm per microsecond tick.
  localparam int              CM_SCALE_W = 11;
  localparam logic [10:0]     CM_SCALE   = 11'd1124;
  localparam int              CM_SHIFT   = 16;
  localparam int              PROD_W     = PULSE_W + CM_SCALE_W;

  localparam logic [CM_W-1:0] NEAREST_INIT = 14'd9999;
  localparam logic [CM_W-1:0] SHOWN_NONE   = 14'd16383;

  localparam logic [LIMIT_W-1:0] NEAR_RESET = 14'd10;
  localparam logic [LIMIT_W-1:0] FAR_RESET  = 14'd100;

  // Configuration register indexes.
  localparam int          CFG_ADDR_W = 1;
  localparam logic [0:0]  REG_NEAR   = 1'b0;
  localparam logic [0:0]  REG_FAR    = 1'b1;

  typedef enum logic [1:0] {
    LVL_FAR    = 2'd0,
    LVL_PROX   = 2'd1,
    LVL_DANGER = 2'd2,
    LVL_NONE   = 2'd3
  } level_t;

  typedef struct packed {
    logic               valid;
    logic [PULSE_W-1:0] width;
  } pulse_beat_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] near_limit;
    logic [LIMIT_W-1:0] far_limit;
  } limits_t;

endpackage

>>> design/ertt_pulse.sv
// Pulse width stage: counts timer overflows and pairs echo captures.
// Depends on ertt_pkg; feeds ertt_threat with a registered pulse width.
module ertt_pulse import ertt_pkg::*; #(
  parameter int TIMER_BITS = ERTT_TIMER_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic             overflow_event,
  input  logic             capture_event,
  input  logic [CAP_W-1:0] capture_value,
  output pulse_beat_t      pulse
);

  localparam int KEEP_W = (TIMER_BITS < CAP_W) ? TIMER_BITS : CAP_W;

  logic [WRAP_W-1:0]  wrap_count;
  logic [CAP_W-1:0]   start_ticks;
  logic               await_falling;

  logic [WRAP_W-1:0]  wrap_next;
  logic [CAP_W-1:0]   cap_masked;
  logic [PULSE_W-1:0] wrap_term;
  logic [PULSE_W-1:0] end_ticks;
  logic [PULSE_W-1:0] width_next;

  always_comb begin
    wrap_next  = overflow_event ? wrap_count + 1'b1 : wrap_count;
    cap_masked = CAP_W'(capture_value[KEEP_W-1:0]);
    // The count of wraps sits above the timer bits; anything past bit 31 is lost.
    wrap_term  = PULSE_W'(64'(wrap_next) << TIMER_BITS);
    end_ticks  = PULSE_W'(cap_masked) + wrap_term;
    width_next = end_ticks - PULSE_W'(start_ticks);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_count    <= '0;
      start_ticks   <= '0;
      await_falling <= 1'b0;
      pulse.valid   <= 1'b0;
    end else if (en) begin
      pulse.valid <= in_valid && capture_event && await_falling;
      pulse.width <= width_next;
      if (in_valid) begin
        if (!capture_event) begin
          wrap_count <= wrap_next;
        end else if (!await_falling) begin
          wrap_count    <= '0;
          start_ticks   <= cap_masked;
          await_falling <= 1'b1;
        end else begin
          wrap_count    <= wrap_next;
          await_falling <= 1'b0;
        end
      end
    end
  end

  // A new pulse only appears when a falling capture closes an open one.
  a_pulse_closes: assert property (@(posedge clk) disable iff (rst)
    $rose(pulse.valid) |-> ($past(await_falling) && !await_falling))
    else $error("pulse issued without an open capture");

endmodule

>>> design/ertt_threat.sv
// Range and threat stage: converts pulse width to centimetres, tracks the
// closest echo and classifies it. Depends on ertt_pkg; holds the result register.
module ertt_threat import ertt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  pulse_beat_t       pulse,
  input  limits_t           limits,
  output logic              res_valid,
  output logic [DIST_W-1:0] distance_cm,
  output logic [CM_W-1:0]   closest_cm,
  output level_t            hazard_level,
  output logic              threat_changed,
  output logic              show_closest
);

  logic [CM_W-1:0]   nearest_seen;
  level_t            prior_level;
  logic [CM_W-1:0]   last_shown;

  logic [PROD_W-1:0] product;
  logic [DIST_W-1:0] range_cm;
  logic [CM_W-1:0]   nearest_next;
  level_t            level;
  logic              changed;
  logic [CM_W-1:0]   shown_base;
  logic              show;

  always_comb begin
    product      = PROD_W'(pulse.width) * PROD_W'(CM_SCALE);
    range_cm     = product[CM_SHIFT +: DIST_W];
    nearest_next = (range_cm < DIST_W'(nearest_seen)) ? range_cm[CM_W-1:0] : nearest_seen;
    priority if (nearest_next < limits.near_limit) begin
      level = LVL_DANGER;
    end else if (nearest_next <= limits.far_limit) begin
      level = LVL_PROX;
    end else begin
      level = LVL_FAR;
    end
    changed    = (level != prior_level);
    // Entering proximity forgets what was last shown.
    shown_base = (changed && level == LVL_PROX) ? SHOWN_NONE : last_shown;
    show       = (level == LVL_PROX) && (nearest_next != shown_base);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nearest_seen <= NEAREST_INIT;
      prior_level  <= LVL_NONE;
      last_shown   <= SHOWN_NONE;
      res_valid    <= 1'b0;
    end else if (en) begin
      res_valid <= pulse.valid;
      if (pulse.valid) begin
        nearest_seen <= nearest_next;
        prior_level  <= level;
        last_shown   <= show ? nearest_next : shown_base;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && pulse.valid) begin
      distance_cm    <= range_cm;
      closest_cm     <= nearest_next;
      hazard_level   <= level;
      threat_changed <= changed;
      show_closest   <= show;
    end
  end

  a_nearest_bounded: assert property (@(posedge clk) disable iff (rst)
    nearest_seen <= NEAREST_INIT)
    else $error("closest distance above its initial value");

  a_nearest_falls: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> nearest_seen <= $past(nearest_seen))
    else $error("closest distance grew");

endmodule

>>> design/echo_range_threat_tracker_top.sv
// Top level of the echo range threat tracker: stream ports, configuration
// registers, input register and the two processing stages. Depends on
// ertt_pkg, ertt_pulse and ertt_threat.
//
//  Channel  Direction  Signals                       Content
//  s_*      in         tvalid tready tdata tuser     one timer event per transfer
//  m_*      out        tvalid tready tdata           one range result per transfer
//  cfg_*    in         cfg_we cfg_addr cfg_data      limit register writes
//
// Every transfer passes through three registers: input, pulse width, result.
// A new transfer is taken in every cycle unless the output stalls. The constant
// multiply sits in the last stage, between the pulse width and result registers.
// Reset is synchronous and clears all control state and the tracking state.
// The whole pipeline advances whenever the result register is empty or taken,
// so a stall on the output holds every stage and drops s_tready.
module echo_range_threat_tracker_top import ertt_pkg::*; #(
  parameter int TIMER_BITS = ERTT_TIMER_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [15:0] capture_value
  input  logic [USER_W-1:0]     s_tuser,   // [0] overflow_event, [1] capture_event
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [26:0] distance_cm, [40:27] closest_cm, [42:41] hazard_level,
  // [43] threat_changed, [44] show_closest, [47:45] zero
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [LIMIT_W-1:0]    cfg_data
);

  logic              en;
  limits_t           limits;

  logic              in_valid;
  logic              in_overflow;
  logic              in_capture;
  logic [CAP_W-1:0]  in_value;

  pulse_beat_t       pulse;

  logic [DIST_W-1:0] distance_cm;
  logic [CM_W-1:0]   closest_cm;
  level_t            hazard_level;
  logic              threat_changed;
  logic              show_closest;

  // The pipeline moves when the result register is free or being emptied.
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Limit registers; writes must arrive only while idle, not enforced by the block.
  always_ff @(posedge clk) begin
    if (rst) begin
      limits.near_limit <= NEAR_RESET;
      limits.far_limit  <= FAR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_NEAR: limits.near_limit <= cfg_data;
        REG_FAR:  limits.far_limit  <= cfg_data;
        default:  ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (en) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s_tvalid) begin
      in_overflow <= s_tuser[0];
      in_capture  <= s_tuser[1];
      in_value    <= s_tdata[CAP_W-1:0];
    end
  end

  ertt_pulse #(
    .TIMER_BITS(TIMER_BITS)
  ) u_pulse (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .in_valid       (in_valid),
    .overflow_event (in_overflow),
    .capture_event  (in_capture),
    .capture_value  (in_value),
    .pulse          (pulse)
  );

  ertt_threat u_threat (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .pulse          (pulse),
    .limits         (limits),
    .res_valid      (m_tvalid),
    .distance_cm    (distance_cm),
    .closest_cm     (closest_cm),
    .hazard_level   (hazard_level),
    .threat_changed (threat_changed),
    .show_closest   (show_closest)
  );

  assign m_tdata = {3'b000, show_closest, threat_changed, hazard_level,
                    closest_cm, distance_cm};

  // The display line is only refreshed while in proximity.
  a_show_in_prox: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && show_closest) |-> (hazard_level == LVL_PROX))
    else $error("show_closest outside proximity level");

  // The reported closest distance never exceeds the echo that produced it.
  a_closest_le_dist: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (DIST_W'(closest_cm) <= distance_cm || closest_cm == NEAREST_INIT))
    else $error("closest distance larger than current echo");

endmodule

>>> test/ertt_range_checker.sv
// Checker for the echo range threat tracker: watches the input, output and limit
// write channels, keeps its own copy of the tracking state and compares every result.
// Depends on ertt_pkg for widths, level codes and register indexes.
module ertt_range_checker import ertt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [USER_W-1:0]     s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [LIMIT_W-1:0]    cfg_data,
  output int                    outstanding,
  output int                    fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [CM_W-1:0]   closest;
    level_t            level;
    logic              changed;
    logic              show;
  } range_result_t;

  logic [WRAP_W-1:0]  wraps;
  logic [CAP_W-1:0]   echo_start;
  logic               echo_open;
  logic [CM_W-1:0]    nearest;
  level_t             reported;
  logic [CM_W-1:0]    shown;
  logic [LIMIT_W-1:0] near_lim;
  logic [LIMIT_W-1:0] far_lim;
  range_result_t      range_q[$];
  int                 fails = 0;

  // Updates the tracking state for one timer event; a closing capture queues a result.
  task automatic track_event(input logic ovf, input logic cap, input logic [CAP_W-1:0] ticks);
    logic [PULSE_W-1:0] width;
    logic [63:0]        scaled;
    level_t             lvl;
    range_result_t      r;
    if (ovf) wraps = wraps + 1'b1;
    if (cap) begin
      if (!echo_open) begin
        wraps      = '0;
        echo_start = ticks;
        echo_open  = 1'b1;
      end else begin
        // Width wraps at 32 bits, so an end count below the start gives a huge pulse.
        width  = (PULSE_W'(wraps) << ERTT_TIMER_BITS) + PULSE_W'(ticks)
                 - PULSE_W'(echo_start);
        scaled = (64'(width) * 64'(CM_SCALE)) >> CM_SHIFT;
        echo_open = 1'b0;
        if (scaled < 64'(nearest)) nearest = CM_W'(scaled);
        if (nearest < near_lim) lvl = LVL_DANGER;
        else if (nearest <= far_lim) lvl = LVL_PROX;
        else lvl = LVL_FAR;
        r.changed = (lvl != reported);
        if (r.changed) begin
          reported = lvl;
          if (lvl == LVL_PROX) shown = SHOWN_NONE;
        end
        r.show = (lvl == LVL_PROX) && (nearest != shown);
        if (r.show) shown = nearest;
        r.distance = DIST_W'(scaled);
        r.closest  = nearest;
        r.level    = lvl;
        range_q.push_back(r);
      end
    end
  endtask

  function automatic void check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    range_result_t got;
    range_result_t want;
    if (rst) begin
      wraps      = '0;
      echo_start = '0;
      echo_open  = 1'b0;
      nearest    = NEAREST_INIT;
      reported   = LVL_NONE;
      shown      = SHOWN_NONE;
      near_lim   = NEAR_RESET;
      far_lim    = FAR_RESET;
      range_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_NEAR: near_lim = cfg_data;
          REG_FAR:  far_lim  = cfg_data;
          default:  ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got.distance = m_tdata[26:0];
        got.closest  = m_tdata[40:27];
        got.level    = level_t'(m_tdata[42:41]);
        got.changed  = m_tdata[43];
        got.show     = m_tdata[44];
        if (range_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, m_tdata);
          fails++;
        end else begin
          want = range_q.pop_front();
          check_field("distance_cm", want.distance, got.distance);
          check_field("closest_cm", want.closest, got.closest);
          check_field("hazard_level", want.level, got.level);
          check_field("threat_changed", want.changed, got.changed);
          check_field("show_closest", want.show, got.show);
        end
      end
      if (s_tvalid && s_tready) track_event(s_tuser[0], s_tuser[1], s_tdata[CAP_W-1:0]);
    end
    outstanding <= range_q.size();
    fail_count  <= fails;
  end

endmodule

>>> test/tb_top.sv
// Top of the echo range threat tracker testbench: clock, reset, event stimulus,
// limit writes, output back-pressure and the verdict. Depends on ertt_pkg,
// echo_range_threat_tracker_top and ertt_range_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ertt_pkg::*;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;   // [15:0] capture_value
  logic [USER_W-1:0]     s_tuser  = '0;   // [0] overflow_event, [1] capture_event
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // [26:0] distance_cm, [40:27] closest_cm, [42:41] hazard_level,
  // [43] threat_changed, [44] show_closest, [47:45] zero
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_we   = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = REG_NEAR;
  logic [LIMIT_W-1:0]    cfg_data = '0;

  int outstanding;
  int errors;

  // Count of input transfers that carry an overflow or a capture; idle items
  // that the block merely ignores are left out.
  int fed = 0;
  // While set, neither side inserts idle cycles.
  bit calm = 1'b0;
  // Our own view of whether a pulse has been opened and awaits its closing capture.
  bit echo_armed = 1'b0;

  always #10 clk = ~clk;

  echo_range_threat_tracker_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  ertt_range_checker range_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_data    (cfg_data),
    .outstanding (outstanding),
    .fail_count  (errors)
  );

  // Offers one timer event after a random gap and holds it until the transfer
  // completes. With no gap the valid simply stays high for the next item, so it
  // is never lowered and raised within the same step.
  task automatic feed(input logic ovf, input logic cap, input logic [CAP_W-1:0] ticks);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ticks;
    s_tuser  <= {cap, ovf};
    do @(posedge clk); while (!s_tready);
    if (cap) echo_armed = !echo_armed;
    if (ovf || cap) fed++;
  endtask

  // Stops offering and waits until every expected result has been taken. The
  // first edge lets the checker count a closing capture taken at the last edge;
  // the extra cycles cover events still in the three-stage pipeline that give
  // no result.
  task automatic quiesce();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Writes the near limit, then the far limit, keeping the write enable high
  // between them.
  task automatic set_limits(input logic [LIMIT_W-1:0] near, input logic [LIMIT_W-1:0] far);
    cfg_we   <= 1'b1;
    cfg_addr <= REG_NEAR;
    cfg_data <= near;
    @(posedge clk);
    cfg_addr <= REG_FAR;
    cfg_data <= far;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // A well-formed echo: a rising capture, a few timer wraps, then a falling
  // capture. A pulse left open by a stray capture is closed first. Half the
  // pulses are short, so the closest distance is driven down into the range
  // where the limits matter; the rest span the full count, wrapped ones included.
  task automatic echo_pair();
    logic [CAP_W-1:0] rise;
    logic [CAP_W-1:0] fall;
    int               pick;
    int               wrap_n;
    if (echo_armed) feed(1'($urandom_range(0, 1)), 1'b1, CAP_W'($urandom));
    rise = CAP_W'($urandom);
    feed($urandom_range(0, 3) == 0, 1'b1, rise);
    pick = $urandom_range(0, 9);
    if (pick < 5) wrap_n = 0;
    else if (pick < 8) wrap_n = 1;
    else if (pick < 9) wrap_n = 2;
    else wrap_n = $urandom_range(3, 20);
    repeat (wrap_n) feed(1'b1, 1'b0, CAP_W'($urandom));
    if ($urandom_range(0, 1) == 0) fall = rise + CAP_W'($urandom_range(0, 1500));
    else fall = CAP_W'($urandom);
    feed($urandom_range(0, 3) == 0, 1'b1, fall);
  endtask

  // Output side: a random hold-off before each result, none in calm phases.
  // Once, part way through the run, the receiver holds off for a long stretch
  // while the sender keeps offering, so the pipeline fills and s_tready drops.
  initial begin
    int  gap;
    bit  long_done;
    long_done = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (!long_done && fed >= 350) begin
        gap = 150;
        long_done = 1'b1;
      end else begin
        gap = calm ? 0 : $urandom_range(0, 7);
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  initial begin
    int stop;
    int pick;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part, with the limits at their reset values of 10 and 100.
    // An idle item and two lone overflows while no pulse is open.
    feed(1'b0, 1'b0, 16'h1234);
    feed(1'b1, 1'b0, 16'h0000);
    feed(1'b1, 1'b0, 16'hFFFF);
    // Rising capture with an overflow in the same item: the count is cleared.
    // The falling capture below the start wraps to a pulse near 2^32 ticks,
    // reported as far, and the first report always counts as a change.
    feed(1'b1, 1'b1, 16'hFFFF);
    feed(1'b0, 1'b1, 16'h0000);
    // Pulse spanning three wraps; the closing overflow is counted before the capture.
    feed(1'b0, 1'b1, 16'd100);
    feed(1'b1, 1'b0, 16'd0);
    feed(1'b1, 1'b0, 16'd0);
    feed(1'b1, 1'b1, 16'd50);
    // Entering the proximity level: the closest distance is shown.
    feed(1'b0, 1'b1, 16'd0);
    feed(1'b0, 1'b1, 16'd2915);
    // Same distance again: nothing new to show.
    feed(1'b0, 1'b1, 16'd1000);
    feed(1'b0, 1'b1, 16'd3915);
    // A farther echo with an overflow-only item mid-pulse, then a closer one in proximity.
    feed(1'b0, 1'b1, 16'd0);
    feed(1'b1, 1'b0, 16'd7);
    feed(1'b0, 1'b1, 16'd2334 - 16'd1);
    feed(1'b0, 1'b1, 16'd0);
    feed(1'b0, 1'b1, 16'd1000);
    // Below the near limit: danger level.
    feed(1'b0, 1'b1, 16'd65000);
    feed(1'b0, 1'b1, 16'd65400);
    quiesce();

    // Random part in phases; the limits change only between phases, while the
    // block is idle, and the extremes come first.
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: set_limits({LIMIT_W{1'b1}}, {LIMIT_W{1'b1}});
        1: set_limits('0, '0);
        2: set_limits('0, {LIMIT_W{1'b1}});
        3: set_limits(LIMIT_W'(9999), '0);
        4: set_limits(NEAR_RESET, FAR_RESET);
        5: set_limits(LIMIT_W'($urandom), LIMIT_W'($urandom));
        default: set_limits(LIMIT_W'($urandom_range(0, 12)), LIMIT_W'($urandom_range(0, 30)));
      endcase
      calm = (ph % 4 == 2);
      stop = fed + 100;
      while (fed < stop) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) echo_pair();
        else if (pick == 7) feed(1'($urandom_range(0, 1)), 1'b0, CAP_W'($urandom));
        else if (pick == 8) feed(1'($urandom_range(0, 1)), 1'b1, CAP_W'($urandom));
        else repeat ($urandom_range(2, 12)) feed(1'b1, 1'b0, CAP_W'($urandom));
      end
      quiesce();
    end

    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // Guard against a hung handshake; far beyond the slowest correct run.
  initial begin
    #8000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> files.f
design/ertt_pkg.sv
design/ertt_pulse.sv
design/ertt_threat.sv
design/echo_range_threat_tracker_top.sv
test/ertt_range_checker.sv
test/tb_top.sv
